// File: src/cscmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscmv_pkg
// Shared types and constants of the CSC sparse matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package cscmv_pkg;

  localparam int DEF_MAX_DIM     = 64;
  localparam int DEF_MAX_NONZERO = 1024;
  localparam int CMD_FIFO_DEPTH  = 4;

  localparam int PTR_W   = 17;
  localparam int ACC_W   = 48;
  localparam int VAL_W   = 32;
  localparam int ROW_W   = 7;
  localparam int SLOT_W  = 10;
  localparam int CPTR_W  = 11;
  localparam int DIM_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int OIDX_W  = 6;

  typedef enum logic [1:0] {
    REQ_LD_PTR = 2'd0,
    REQ_LD_NZ  = 2'd1,
    REQ_LD_VEC = 2'd2,
    REQ_RUN    = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS   = 3'd0,
    CFG_NUM_COLS   = 3'd1,
    CFG_INDEX_BASE = 3'd2,
    CFG_TRANSPOSE  = 3'd3,
    CFG_SUBTRACT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    req_t                    op;
    logic [SLOT_W-1:0]       slot;
    logic [ROW_W-1:0]        row;
    logic [CPTR_W-1:0]       ptr;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: src/cscmv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cscmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/cscmv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscmv_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cscmv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= din;
    end
  end

endmodule

// File: src/cscmv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscmv_front
// Accepts request transactions, drops loads aimed past their store and
// queues the rest as commands.
// ----------------------------------------------------------------------------
module cscmv_front
  import cscmv_pkg::*;
#(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_NONZERO = DEF_MAX_NONZERO
) (
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              req_type,
  input  logic [SLOT_W-1:0]       slot,
  input  logic [ROW_W-1:0]        entry_row,
  input  logic [CPTR_W-1:0]       col_pointer,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    q_full,
  output logic                    q_push,
  output cmd_t                    q_cmd
);

  logic keep;

  always_comb begin
    q_cmd.op    = req_t'(req_type);
    q_cmd.slot  = slot;
    q_cmd.row   = entry_row;
    q_cmd.ptr   = col_pointer;
    q_cmd.value = value;
    case (q_cmd.op)
      REQ_LD_PTR: keep = (32'(slot) < MAX_DIM + 1);
      REQ_LD_NZ:  keep = (32'(slot) < MAX_NONZERO);
      REQ_LD_VEC: keep = (32'(slot) < MAX_DIM);
      REQ_RUN:    keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

endmodule

// File: src/cscmv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscmv_back
// Executes queued commands: writes the stores, walks the columns on a run,
// accumulates products and emits the saturated result vector.
// ----------------------------------------------------------------------------
module cscmv_back
  import cscmv_pkg::*;
#(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_NONZERO = DEF_MAX_NONZERO
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     q_empty,
  input  cmd_t                     q_cmd,
  output logic                     q_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic [OIDX_W-1:0]        out_index,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     last
);

  localparam int DA = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CA = $clog2(MAX_DIM + 1);
  localparam int NA = $clog2(MAX_NONZERO);
  localparam int NZ_W = ROW_W + VAL_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CA   = 11'b00000000010,
    S_CB   = 11'b00000000100,
    S_CC   = 11'b00000001000,
    S_NZ   = 11'b00000010000,
    S_NZD  = 11'b00000100000,
    S_VEC  = 11'b00001000000,
    S_RND  = 11'b00010000000,
    S_ACC  = 11'b00100000000,
    S_ERD  = 11'b01000000000,
    S_EOUT = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] nr, nc;
  logic             base, trans, sub;
  logic [CA-1:0]    c, c_next;
  logic [PTR_W-1:0] ri, ri_next, re, re_next;
  logic [DA-1:0]    acc_idx, acc_idx_next;
  logic [DA-1:0]    k, k_next;
  logic signed [VAL_W-1:0]     val, val_next;
  logic signed [2*VAL_W-1:0]   prod;
  logic signed [ACC_W-1:0]     pround;
  logic [MAX_DIM-1:0]          acc_valid;
  logic                        ovalid;

  logic [CPTR_W-1:0]  col_rdata;
  logic [NZ_W-1:0]    nz_rdata;
  logic [VAL_W-1:0]   vec_rdata;
  logic [ACC_W-1:0]   acc_rdata;
  logic               col_re, nz_re, vec_re, acc_re, acc_we;
  logic [CA-1:0]      col_raddr;
  logic [DA-1:0]      vec_raddr, acc_raddr;
  logic [ACC_W-1:0]   acc_wdata;

  logic [PTR_W-1:0]   col_db;
  logic [ROW_W-1:0]   nz_row;
  logic [ROW_W-1:0]   row_db;
  logic               row_ok;
  logic [DIM_W-1:0]   n_out;
  logic               col_last;
  logic               emit;
  logic signed [ACC_W-1:0] acc_cur;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [VAL_W-1:0] out_sat;
  logic [DIM_W-1:0]   cfg_dim;

  cscmv_ram #(.WIDTH(CPTR_W), .DEPTH(MAX_DIM + 1)) u_col_ram (
    .clk(clk), .we(state == S_IDLE && !q_empty && q_cmd.op == REQ_LD_PTR),
    .waddr(CA'(q_cmd.slot)), .wdata(q_cmd.ptr),
    .re(col_re), .raddr(col_raddr), .rdata(col_rdata)
  );

  cscmv_ram #(.WIDTH(NZ_W), .DEPTH(MAX_NONZERO)) u_nz_ram (
    .clk(clk), .we(state == S_IDLE && !q_empty && q_cmd.op == REQ_LD_NZ),
    .waddr(NA'(q_cmd.slot)), .wdata({q_cmd.row, q_cmd.value}),
    .re(nz_re), .raddr(ri[NA-1:0]), .rdata(nz_rdata)
  );

  cscmv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vec_ram (
    .clk(clk), .we(state == S_IDLE && !q_empty && q_cmd.op == REQ_LD_VEC),
    .waddr(DA'(q_cmd.slot)), .wdata(q_cmd.value),
    .re(vec_re), .raddr(vec_raddr), .rdata(vec_rdata)
  );

  cscmv_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DIM)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_idx), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // remove index base from a stored pointer
  assign col_db = (col_rdata >= CPTR_W'(base)) ? PTR_W'(col_rdata - CPTR_W'(base)) : '0;
  assign nz_row = nz_rdata[NZ_W-1:VAL_W];
  assign row_db = nz_row - ROW_W'(base);
  assign row_ok = (nz_row >= ROW_W'(base)) && (row_db < nr);
  assign n_out  = trans ? nc : nr;
  assign col_last = (DIM_W'(c) + DIM_W'(1) == nc);
  assign emit   = (state == S_EOUT) && (!ovalid || pop);

  assign col_re    = (state == S_CA) || (state == S_CB);
  assign col_raddr = (state == S_CB) ? c + CA'(1) : c;
  assign nz_re     = (state == S_NZ);
  assign vec_re    = (state == S_NZD) && row_ok;
  assign vec_raddr = trans ? DA'(row_db) : DA'(c);
  assign acc_re    = ((state == S_NZD) && row_ok) || (state == S_ERD);
  assign acc_raddr = (state == S_ERD) ? k : (trans ? DA'(c) : DA'(row_db));

  assign acc_cur = acc_valid[acc_idx] ? signed'(acc_rdata) : '0;
  assign acc_sum = sub ? {acc_cur[ACC_W-1], acc_cur} - {pround[ACC_W-1], pround}
                       : {acc_cur[ACC_W-1], acc_cur} + {pround[ACC_W-1], pround};
  assign acc_we  = (state == S_ACC);

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_wdata = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_wdata = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    logic [ACC_W-1:0] a;
    a = acc_valid[k] ? acc_rdata : '0;
    if (!a[ACC_W-1] && (a[ACC_W-2:VAL_W-1] != '0)) begin
      out_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (a[ACC_W-1] && (a[ACC_W-2:VAL_W-1] != '1)) begin
      out_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      out_sat = a[VAL_W-1:0];
    end
  end

  always_comb begin
    cfg_dim = cfg_data;
    if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (32'(cfg_data) > MAX_DIM) begin
      cfg_dim = DIM_W'(MAX_DIM);
    end
  end

  always_comb begin
    state_next   = state;
    c_next       = c;
    ri_next      = ri;
    re_next      = re;
    acc_idx_next = acc_idx;
    k_next       = k;
    val_next     = val;
    q_pop        = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.op == REQ_RUN) begin
            c_next     = '0;
            state_next = S_CA;
          end
        end
      end
      S_CA: state_next = S_CB;
      S_CB: begin
        ri_next    = col_db;
        state_next = S_CC;
      end
      S_CC: begin
        re_next = (col_db > PTR_W'(MAX_NONZERO)) ? PTR_W'(MAX_NONZERO) : col_db;
        if (ri < re_next) begin
          state_next = S_NZ;
        end else if (col_last) begin
          k_next     = '0;
          state_next = S_ERD;
        end else begin
          c_next     = c + CA'(1);
          state_next = S_CA;
        end
      end
      S_NZ: state_next = S_NZD;
      S_NZD: begin
        val_next     = signed'(nz_rdata[VAL_W-1:0]);
        acc_idx_next = acc_raddr;
        if (row_ok) begin
          state_next = S_VEC;
        end else if (ri + PTR_W'(1) < re) begin
          ri_next    = ri + PTR_W'(1);
          state_next = S_NZ;
        end else if (col_last) begin
          k_next     = '0;
          state_next = S_ERD;
        end else begin
          c_next     = c + CA'(1);
          state_next = S_CA;
        end
      end
      S_VEC: state_next = S_RND;
      S_RND: state_next = S_ACC;
      S_ACC: begin
        if (ri + PTR_W'(1) < re) begin
          ri_next    = ri + PTR_W'(1);
          state_next = S_NZ;
        end else if (col_last) begin
          k_next     = '0;
          state_next = S_ERD;
        end else begin
          c_next     = c + CA'(1);
          state_next = S_CA;
        end
      end
      S_ERD: state_next = S_EOUT;
      S_EOUT: begin
        if (emit) begin
          if (DIM_W'(k) + DIM_W'(1) == n_out) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + DA'(1);
            state_next = S_ERD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nr        <= DIM_W'(MAX_DIM);
      nc        <= DIM_W'(MAX_DIM);
      base      <= 1'b0;
      trans     <= 1'b0;
      sub       <= 1'b0;
      acc_valid <= '0;
      ovalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_ROWS:   nr    <= cfg_dim;
          CFG_NUM_COLS:   nc    <= cfg_dim;
          CFG_INDEX_BASE: base  <= cfg_data[0];
          CFG_TRANSPOSE:  trans <= cfg_data[0];
          CFG_SUBTRACT:   sub   <= cfg_data[0];
          default: ;
        endcase
      end
      if (acc_we) begin
        acc_valid[acc_idx] <= 1'b1;
      end
      if (emit) begin
        acc_valid[k] <= 1'b0;
        ovalid       <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c       <= c_next;
    ri      <= ri_next;
    re      <= re_next;
    acc_idx <= acc_idx_next;
    k       <= k_next;
    val     <= val_next;
    if (state == S_VEC) begin
      prod <= val * signed'(vec_rdata);
    end
    if (state == S_RND) begin
      pround <= ACC_W'((prod + (2*VAL_W)'(32768)) >>> 16);
    end
    if (emit) begin
      out_index <= OIDX_W'(k);
      out_value <= out_sat;
      last      <= (DIM_W'(k) + DIM_W'(1) == n_out);
    end
  end

  assign empty = !ovalid;

endmodule

// File: src/csc_sparse_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_sparse_matrix_vector_multiply_unit
// Compressed sparse column matrix times vector in Q16.16 fixed point.
//
//   channel   handshake        payload
//   request   push / full      req_type slot entry_row col_pointer value
//   result    empty / pop      out_index out_value last
//   config    cfg_write        cfg_index cfg_data
//
// a load is written into its store in the same cycle that it leaves the command queue
// a run steps through CA, CB, CC per column, NZ, NZD, VEC, RND, ACC per used entry,
// NZ, NZD per skipped entry and ERD, EOUT per result, set by the single-port sequencer over the stores
// result pops stall emission only; requests queue while a run is active
// reset is synchronous and clears the accumulators through valid bits
// ----------------------------------------------------------------------------
module csc_sparse_matrix_vector_multiply_unit
  import cscmv_pkg::*;
#(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_NONZERO = DEF_MAX_NONZERO
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              req_type,
  input  logic [SLOT_W-1:0]       slot,
  input  logic [ROW_W-1:0]        entry_row,
  input  logic [CPTR_W-1:0]       col_pointer,
  input  logic signed [VAL_W-1:0] value,
  output logic                    empty,
  input  logic                    pop,
  output logic [OIDX_W-1:0]       out_index,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    last,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_in, q_out;
  logic [$bits(cmd_t)-1:0] q_dout;

  cscmv_front #(.MAX_DIM(MAX_DIM), .MAX_NONZERO(MAX_NONZERO)) u_front (
    .push(push), .full(full), .req_type(req_type), .slot(slot),
    .entry_row(entry_row), .col_pointer(col_pointer), .value(value),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_in)
  );

  cscmv_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .wr(q_push), .din(q_in), .full(q_full),
    .rd(q_pop), .dout(q_dout), .empty(q_empty)
  );

  assign q_out = cmd_t'(q_dout);

  cscmv_back #(.MAX_DIM(MAX_DIM), .MAX_NONZERO(MAX_NONZERO)) u_back (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_empty(q_empty), .q_cmd(q_out), .q_pop(q_pop),
    .empty(empty), .pop(pop), .out_index(out_index), .out_value(out_value),
    .last(last)
  );

endmodule

// File: src/cscmv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscmv_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cscmv_checker
  import cscmv_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    push,
  input logic                    full,
  input logic [1:0]              req_type,
  input logic                    empty,
  input logic                    pop,
  input logic [OIDX_W-1:0]       out_index,
  input logic signed [VAL_W-1:0] out_value,
  input logic                    last
);

  logic [OIDX_W-1:0] exp_idx;
  logic [3:0]        runs;
  logic              run_in, run_done;

  assign run_in   = push && !full && (req_type == REQ_RUN);
  assign run_done = pop && !empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
      runs    <= '0;
    end else begin
      if (pop && !empty) begin
        exp_idx <= last ? '0 : exp_idx + OIDX_W'(1);
      end
      if (run_in && !run_done) begin
        runs <= runs + 4'd1;
      end else if (run_done && !run_in) begin
        runs <= runs - 4'd1;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_index) && $stable(out_value) && $stable(last))
    else $error("result changed while waiting");

  a_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_index == exp_idx)
    else $error("result index out of order");

  a_no_run: assert property (@(posedge clk) disable iff (rst)
    !empty |-> runs != 4'd0)
    else $error("result without a run");

  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

endmodule

bind csc_sparse_matrix_vector_multiply_unit cscmv_checker u_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
  .empty(empty), .pop(pop), .out_index(out_index), .out_value(out_value),
  .last(last)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the CSC sparse matrix-vector multiply unit against a behavioral
// predictor: loads random well-formed matrices and vectors, runs them under
// several register settings and compares every emitted element in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cscmv_pkg::*;

  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct {
    logic [OIDX_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
    logic                    lst;
  } elem_t;

  class spmv_scoreboard;
    logic [CPTR_W-1:0]       col_start [DEF_MAX_DIM+1];
    logic [ROW_W-1:0]        nz_row [DEF_MAX_NONZERO];
    logic signed [VAL_W-1:0] nz_val [DEF_MAX_NONZERO];
    logic signed [VAL_W-1:0] vec [DEF_MAX_DIM];
    longint                  acc [DEF_MAX_DIM];
    int unsigned             rows_cfg = 64, cols_cfg = 64;
    bit                      base, trans, subt;
    elem_t                   pending [$];
    int                      errors, matched, runs;

    function new();
      foreach (acc[i]) acc[i] = 0;
      foreach (col_start[i]) col_start[i] = '0;
      foreach (nz_row[i]) begin
        nz_row[i] = '0;
        nz_val[i] = '0;
      end
      foreach (vec[i]) vec[i] = '0;
    endfunction

    function int unsigned clampd(int unsigned d);
      return d < 1 ? 1 : (d > DEF_MAX_DIM ? DEF_MAX_DIM : d);
    endfunction

    function longint qmul(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b) + 32768;
      return p >>> 16;
    endfunction

    function void note_request(req_t op, int unsigned sl, logic [ROW_W-1:0] er,
                               logic [CPTR_W-1:0] cp, logic signed [VAL_W-1:0] v);
      int unsigned nr, nc, ri, re, r, n, tgt;
      longint s, a, p;
      elem_t e;
      case (op)
        REQ_LD_PTR: if (sl < DEF_MAX_DIM + 1) col_start[sl] = cp;
        REQ_LD_NZ: if (sl < DEF_MAX_NONZERO) begin
          nz_row[sl] = er;
          nz_val[sl] = v;
        end
        REQ_LD_VEC: if (sl < DEF_MAX_DIM) vec[sl] = v;
        default: begin
          runs++;
          nr = clampd(rows_cfg);
          nc = clampd(cols_cfg);
          for (int c = 0; c < nc; c++) begin
            ri = col_start[c] >= base ? col_start[c] - base : 0;
            re = col_start[c+1] >= base ? col_start[c+1] - base : 0;
            if (re > DEF_MAX_NONZERO) re = DEF_MAX_NONZERO;
            for (; ri < re; ri++) begin
              r = nz_row[ri];
              if (r < base) continue;
              r -= base;
              if (r >= nr) continue;
              p = trans ? qmul(nz_val[ri], vec[r]) : qmul(nz_val[ri], vec[c]);
              tgt = trans ? c : r;
              s = subt ? acc[tgt] - p : acc[tgt] + p;
              if (s > ACC_HI) s = ACC_HI;
              if (s < ACC_LO) s = ACC_LO;
              acc[tgt] = s;
            end
          end
          n = trans ? nc : nr;
          for (int k = 0; k < n; k++) begin
            a = acc[k];
            if (a > 64'sd2147483647) a = 64'sd2147483647;
            if (a < -64'sd2147483648) a = -64'sd2147483648;
            e.idx = OIDX_W'(k);
            e.val = a[31:0];
            e.lst = (k + 1 == n);
            pending.push_back(e);
          end
          foreach (acc[i]) acc[i] = 0;
        end
      endcase
    endfunction

    function void check_element(logic [OIDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                                logic lst);
      elem_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected element idx=%0d val=%0d last=%0b", $time, idx, val, lst);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (idx !== e.idx || val !== e.val || lst !== e.lst) begin
        $display("%0t: mismatch expected idx=%0d val=%0d last=%0b actual idx=%0d val=%0d last=%0b",
                 $time, e.idx, e.val, e.lst, idx, val, lst);
        errors++;
      end else
        matched++;
    endfunction
  endclass

  logic                    clk, rst, push, pop, cfg_write;
  logic                    full, empty, last;
  logic [1:0]              req_type;
  logic [SLOT_W-1:0]       slot;
  logic [ROW_W-1:0]        entry_row;
  logic [CPTR_W-1:0]       col_pointer;
  logic signed [VAL_W-1:0] value, out_value;
  logic [OIDX_W-1:0]       out_index;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  spmv_scoreboard sb = new();
  bit calm_phase;
  int items_sent;

  csc_sparse_matrix_vector_multiply_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && !empty && pop) sb.check_element(out_index, out_value, last);
    if (!rst) pop <= calm_phase ? 1'b1 : ($urandom_range(99) >= 6);
  end

  // push stays high after a transaction so the next one can follow directly
  task automatic send(req_t op, int unsigned sl, logic [ROW_W-1:0] er,
                      logic [CPTR_W-1:0] cp, logic signed [VAL_W-1:0] v);
    while (!calm_phase && $urandom_range(99) < 6) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= op;
    slot <= SLOT_W'(sl);
    entry_row <= er;
    col_pointer <= cp;
    value <= v;
    do @(posedge clk); while (full);
    sb.note_request(op, sl, er, cp, v);
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(d);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_NUM_ROWS:   sb.rows_cfg = d & 127;
      CFG_NUM_COLS:   sb.cols_cfg = d & 127;
      CFG_INDEX_BASE: sb.base = d[0];
      CFG_TRANSPOSE:  sb.trans = d[0];
      default:        sb.subt = d[0];
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(65536 * 4)) - 65536 * 2;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  // loads a full matrix for the current shape, every referenced slot written
  task automatic load_matrix(int unsigned nr, int unsigned nc, int unsigned maxper);
    int unsigned pos, cnt, b;
    b = sb.base;
    pos = 0;
    for (int c = 0; c < nc; c++) begin
      cnt = $urandom_range(maxper);
      send(REQ_LD_PTR, c, $urandom, pos + b, $urandom);
      for (int k = 0; k < cnt; k++) begin
        // occasionally a row that is out of range or below the base
        send(REQ_LD_NZ, pos + k,
             ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(nr - 1) + b,
             $urandom, rand_value());
      end
      pos += cnt;
    end
    send(REQ_LD_PTR, nc, $urandom, pos + b, $urandom);
    for (int i = 0; i < DEF_MAX_DIM; i++)
      if (i < nr || i < nc) send(REQ_LD_VEC, i, $urandom, $urandom, rand_value());
  endtask

  task automatic phase(int unsigned nr, int unsigned nc, bit b, bit t, bit s,
                       int unsigned maxper, int unsigned runs);
    drain();
    write_reg(CFG_NUM_ROWS, nr);
    write_reg(CFG_NUM_COLS, nc);
    write_reg(CFG_INDEX_BASE, b);
    write_reg(CFG_TRANSPOSE, t);
    write_reg(CFG_SUBTRACT, s);
    load_matrix(nr < 1 ? 1 : (nr > 64 ? 64 : nr), nc < 1 ? 1 : (nc > 64 ? 64 : nc), maxper);
    repeat (runs) send(REQ_RUN, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst = 1; push = 0; pop = 0; cfg_write = 0;
    req_type = '0; slot = '0; entry_row = '0; col_pointer = '0; value = '0;
    cfg_index = '0; cfg_data = '0; calm_phase = 0; items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tiny matrix, extreme values, ignored out-of-range loads
    write_reg(CFG_NUM_ROWS, 2);
    write_reg(CFG_NUM_COLS, 2);
    send(REQ_LD_PTR, 0, 0, 0, 0);
    send(REQ_LD_PTR, 1, 0, 2, 0);
    send(REQ_LD_PTR, 2, 0, 4, 0);
    send(REQ_LD_NZ, 0, 0, 0, 32'sh7fffffff);
    send(REQ_LD_NZ, 1, 1, 0, 32'sh80000000);
    send(REQ_LD_NZ, 2, 1, 0, 32'sh00010000);
    send(REQ_LD_NZ, 3, 127, 0, 32'sh00008000);
    send(REQ_LD_VEC, 0, 0, 0, 32'sh7fffffff);
    send(REQ_LD_VEC, 1, 0, 0, 32'sh80000000);
    send(REQ_LD_PTR, 1023, 127, 2047, 32'shffffffff);
    send(REQ_LD_NZ, 1023, 127, 2047, 32'shffffffff);
    send(REQ_LD_VEC, 1023, 0, 0, 32'sh12345678);
    send(REQ_RUN, 0, 0, 0, 0);
    drain();
    write_reg(CFG_TRANSPOSE, 1);
    send(REQ_RUN, 1023, 127, 2047, 32'shffffffff);
    drain();
    write_reg(CFG_SUBTRACT, 1);
    write_reg(CFG_NUM_ROWS, 0);
    write_reg(CFG_NUM_COLS, 127);
    send(REQ_LD_PTR, 0, 0, 2047, 0);
    for (int i = 1; i <= 64; i++) send(REQ_LD_PTR, i, 0, 2047, 0);
    send(REQ_RUN, 0, 0, 0, 0);

    // random phases
    phase(24, 24, 0, 0, 0, 2, 1);
    calm_phase = 1;
    phase(5, 7, 1, 0, 0, 3, 2);
    calm_phase = 0;
    phase(7, 5, 1, 1, 0, 3, 1);
    phase(64, 3, 0, 1, 1, 2, 1);
    phase(1, 1, 1, 0, 1, 3, 2);
    while (items_sent < 270) begin
      phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1),
            $urandom_range(1), $urandom_range(1), 3, $urandom_range(1, 2));
    end
    drain();
    $display("ran %0d requests and %0d runs, %0d elements matched",
             items_sent, sb.runs, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
